[rtl/core/assert_macros.svh]
// assertion macros, included by dmm_queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define DMM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: check failed");

// implication checked in the cycle after the condition
`define DMM_ASSERT_NEXT(lbl, clk, rstn, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("%m: check failed");

`endif

[rtl/core/dmm_pkg.sv]
// types and constants of the depth map to mesh block
package dmm_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam int COEF_W     = 21;
    localparam int IDX_W      = 22;
    localparam int TRI_W      = 23;
    localparam int XY_W       = 13;
    localparam int GEO_W      = 16;
    localparam int GEOCFG_W   = 12;
    localparam int EPOCH_W    = 8;
    localparam int ACC_W      = 40;
    localparam int PROD_W     = 57;
    localparam int POS_W      = 32;
    localparam int DEPTH_W    = 16;
    localparam int CFG_W      = 63;
    localparam int CFG_ADDR_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int TDATA_W    = 208;

    localparam logic [GEOCFG_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [GEOCFG_W-1:0] HEIGHT_RST = 12'd480;

    // register indexes of the configuration port
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROW0, REG_ROW1, REG_ROW2, REG_TRANS, REG_WIDTH, REG_HEIGHT
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] row0;
        logic [CFG_W-1:0] row1;
        logic [CFG_W-1:0] row2;
        logic [CFG_W-1:0] trans;
    } coef_cfg_t;

    // one entry of the previous row store
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic               valid;
        logic [IDX_W-1:0]   idx;
    } row_ent_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } vref_t;

    // classified pixel handed from front to back
    typedef struct packed {
        logic               has_vtx;
        logic               has_t1;
        logic               has_t2;
        logic               frame_end;
        logic [DEPTH_W-1:0] depth;
        logic [XY_W-1:0]    x;
        logic [XY_W-1:0]    y;
        logic [IDX_W-1:0]   vidx;
        logic [TRI_W-1:0]   tri_base;
        logic [IDX_W-1:0]   ul;
        logic [IDX_W-1:0]   ll;
        logic [IDX_W-1:0]   ur;
    } pix_cmd_t;

    typedef enum logic [1:0] {F_CLEAR, F_IDLE, F_EVAL} front_state_t;

    typedef enum logic [2:0] {B_IDLE, B_MUL, B_SUM, B_PROD, B_FIN, B_EMIT} back_state_t;

endpackage

[rtl/core/depth_map_to_mesh_top.sv]
// top level of the depth map to mesh block
//
// Depth pixels enter on the s_ stream in raster order, one 16-bit depth per
// request; a depth of zero means no vertex. Results leave on the m_ stream:
// a vertex (tuser kind 0) for each valid pixel, then up to two triangles
// (kind 1) when the pixel closes a 2x2 quad. tlast marks the final result of
// a pixel, tuser bit 1 marks results of the frame's final pixel.
// Geometry and the transform are set over the cfg_ write port; the user must
// write them only while idle, the block itself does not enforce it.
// The front registers a pixel in F_IDLE and classifies it in F_EVAL; the back
// takes a request from the queue in B_IDLE, computes each vertex coordinate in
// turn through B_MUL, B_SUM, B_PROD and B_FIN on the one shared multiplier
// chain, and sends one result per cycle from B_EMIT while the receiver is ready.
// After reset, and after every 256th frame, a clearing pass sweeps every entry
// of the previous row store; no pixel is taken meanwhile.
// A stalled receiver holds the result register; a four deep queue lets the
// front go on classifying until it fills, then s_tready drops.
module depth_map_to_mesh_top #(
    parameter int MAX_WIDTH  = dmm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dmm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dmm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dmm_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // depth [15:0]
    input  logic [dmm_pkg::DEPTH_W-1:0]     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // vertex_index, pos_x, pos_y, pos_z, tri_index, corner_a, corner_b, corner_c, pad
    output logic [dmm_pkg::TDATA_W-1:0]     m_tdata,
    // kind, frame_end
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);
    import dmm_pkg::*;

    coef_cfg_t           coef_reg;
    logic [GEOCFG_W-1:0] width_reg;
    logic [GEOCFG_W-1:0] height_reg;

    logic                q_push;
    logic                q_space;
    logic                q_pop;
    logic                q_avail;
    pix_cmd_t            q_in;
    pix_cmd_t            q_out;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg   <= '0;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_ROW0:   coef_reg.row0  <= cfg_wdata;
                REG_ROW1:   coef_reg.row1  <= cfg_wdata;
                REG_ROW2:   coef_reg.row2  <= cfg_wdata;
                REG_TRANS:  coef_reg.trans <= cfg_wdata;
                REG_WIDTH:  width_reg      <= cfg_wdata[GEOCFG_W-1:0];
                REG_HEIGHT: height_reg     <= cfg_wdata[GEOCFG_W-1:0];
                default:    ;
            endcase
        end
    end

    dmm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_space    (q_space),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    dmm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .space     (q_space),
        .pop       (q_pop),
        .pop_data  (q_out),
        .avail     (q_avail)
    );

    dmm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .coef     (coef_reg),
        .q_avail  (q_avail),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/core/dmm_queue.sv]
// short queue of classified pixels between front and back
module dmm_queue #(
    parameter int DEPTH = dmm_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dmm_pkg::pix_cmd_t push_data,
    output logic              space,
    input  logic              pop,
    output dmm_pkg::pix_cmd_t pop_data,
    output logic              avail
);
    import dmm_pkg::*;
    `include "assert_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pix_cmd_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign space    = count_reg != CNT_W'(DEPTH);
    assign avail    = count_reg != '0;
    assign pop_data = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `DMM_ASSERT(a_no_push_full, clk, rst_n, !space |-> !push)
    `DMM_ASSERT(a_no_pop_empty, clk, rst_n, !avail |-> !pop)
    `DMM_ASSERT_NEXT(a_fill_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

[rtl/core/dmm_front.sv]
// front part: accepts pixels, tracks neighbour indices and classifies results
module dmm_front #(
    parameter int MAX_WIDTH  = dmm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dmm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [dmm_pkg::GEOCFG_W-1:0]   width_cfg,
    input  logic [dmm_pkg::GEOCFG_W-1:0]   height_cfg,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dmm_pkg::DEPTH_W-1:0]    s_tdata,
    input  logic                           q_space,
    output logic                           q_push,
    output dmm_pkg::pix_cmd_t              q_data
);
    import dmm_pkg::*;

    localparam int W_BITS = $clog2(MAX_WIDTH);
    localparam int H_BITS = $clog2(MAX_HEIGHT);

    row_ent_t            row_mem [MAX_WIDTH];
    row_ent_t            rd_reg;

    front_state_t        state_reg, state_next;
    logic [W_BITS-1:0]   col_reg, col_next;
    logic [H_BITS-1:0]   row_reg, row_next;
    logic [W_BITS-1:0]   clr_reg, clr_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [IDX_W-1:0]    vcnt_reg, vcnt_next;
    logic [TRI_W-1:0]    tcnt_reg, tcnt_next;
    vref_t               left_reg, left_next;
    vref_t               ul_reg, ul_next;
    logic [DEPTH_W-1:0]  depth_reg;

    logic                mem_we;
    logic [W_BITS-1:0]   mem_wa;
    row_ent_t            mem_wd;

    logic [GEO_W-1:0]    w_eff;
    logic [GEO_W-1:0]    h_eff;
    logic [GEO_W-1:0]    col1;
    logic [GEO_W-1:0]    row1;
    logic                ur_v;
    logic                has_v;
    logic                t1;
    logic                t2;
    logic                end_row;
    logic                end_frame;

    // clamp the configured geometry to the supported range
    always_comb
    begin
        w_eff = GEO_W'(width_cfg);
        if (w_eff == '0)
        begin
            w_eff = GEO_W'(1);
        end
        else if (w_eff > GEO_W'(MAX_WIDTH))
        begin
            w_eff = GEO_W'(MAX_WIDTH);
        end
        h_eff = GEO_W'(height_cfg);
        if (h_eff == '0)
        begin
            h_eff = GEO_W'(1);
        end
        else if (h_eff > GEO_W'(MAX_HEIGHT))
        begin
            h_eff = GEO_W'(MAX_HEIGHT);
        end
    end

    // previous row store, read every cycle at the current column
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_wa] <= mem_wd;
        end
        rd_reg <= row_mem[col_reg];
    end

    // pixel latch
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            depth_reg <= s_tdata;
        end
    end

    // neighbour classification
    always_comb
    begin
        ur_v      = rd_reg.valid && (rd_reg.epoch == epoch_reg);
        has_v     = depth_reg != '0;
        t1        = ul_reg.valid && left_reg.valid && ur_v;
        t2        = left_reg.valid && has_v && ur_v;
        col1      = GEO_W'(col_reg) + GEO_W'(1);
        row1      = GEO_W'(row_reg) + GEO_W'(1);
        end_row   = col1 >= w_eff;
        end_frame = end_row && (row1 >= h_eff);
    end

    // command for the back part
    always_comb
    begin
        q_data.has_vtx   = has_v;
        q_data.has_t1    = t1;
        q_data.has_t2    = t2;
        q_data.frame_end = end_frame;
        q_data.depth     = depth_reg;
        q_data.x         = XY_W'(col_reg);
        q_data.y         = XY_W'(row_reg);
        q_data.vidx      = vcnt_reg;
        q_data.tri_base  = tcnt_reg;
        q_data.ul        = ul_reg.idx;
        q_data.ll        = left_reg.idx;
        q_data.ur        = rd_reg.idx;
    end

    // sequencer and state update
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        clr_next   = clr_reg;
        epoch_next = epoch_reg;
        vcnt_next  = vcnt_reg;
        tcnt_next  = tcnt_reg;
        left_next  = left_reg;
        ul_next    = ul_reg;
        mem_we     = 1'b0;
        mem_wa     = col_reg;
        mem_wd     = '0;
        s_tready   = 1'b0;
        q_push     = 1'b0;
        case (state_reg)
            F_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == W_BITS'(MAX_WIDTH - 1))
                begin
                    clr_next   = '0;
                    state_next = F_IDLE;
                end
            end
            F_IDLE:
            begin
                s_tready = q_space;
                if (s_tvalid && q_space)
                begin
                    state_next = F_EVAL;
                end
            end
            F_EVAL:
            begin
                q_push       = 1'b1;
                mem_we       = 1'b1;
                mem_wd.epoch = epoch_reg;
                mem_wd.valid = has_v;
                mem_wd.idx   = vcnt_reg;
                left_next    = '{valid: has_v, idx: vcnt_reg};
                ul_next      = '{valid: ur_v, idx: rd_reg.idx};
                vcnt_next    = vcnt_reg + IDX_W'(has_v);
                tcnt_next    = tcnt_reg + TRI_W'(t1) + TRI_W'(t2);
                col_next     = col_reg + 1'b1;
                state_next   = F_IDLE;
                if (end_row)
                begin
                    col_next  = '0;
                    left_next = '0;
                    ul_next   = '0;
                    row_next  = (row1 < GEO_W'(MAX_HEIGHT)) ? H_BITS'(row1)
                                                            : H_BITS'(MAX_HEIGHT - 1);
                end
                if (end_frame)
                begin
                    vcnt_next  = '0;
                    tcnt_next  = '0;
                    row_next   = '0;
                    epoch_next = epoch_reg + 1'b1;
                    // epoch wraps: old marks could alias, so wipe the store
                    if (epoch_reg == '1)
                    begin
                        state_next = F_CLEAR;
                    end
                end
            end
            default:
            begin
                state_next = F_CLEAR;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_CLEAR;
            col_reg   <= '0;
            row_reg   <= '0;
            clr_reg   <= '0;
            epoch_reg <= '0;
            vcnt_reg  <= '0;
            tcnt_reg  <= '0;
            left_reg  <= '0;
            ul_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            clr_reg   <= clr_next;
            epoch_reg <= epoch_next;
            vcnt_reg  <= vcnt_next;
            tcnt_reg  <= tcnt_next;
            left_reg  <= left_next;
            ul_reg    <= ul_next;
        end
    end

endmodule

[rtl/core/dmm_back.sv]
// back part: computes vertex positions and sends the results
module dmm_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dmm_pkg::coef_cfg_t           coef,
    input  logic                         q_avail,
    input  dmm_pkg::pix_cmd_t            q_data,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dmm_pkg::TDATA_W-1:0]  m_tdata,
    output logic [1:0]                   m_tuser,
    output logic                         m_tlast
);
    import dmm_pkg::*;

    localparam int PA_W = COEF_W + XY_W + 2;
    localparam logic signed [PROD_W-1:0] POS_MAX = PROD_W'(32'sh7FFFFFFF);
    localparam logic signed [PROD_W-1:0] POS_MIN = -POS_MAX - PROD_W'(1);

    back_state_t              state_reg, state_next;
    pix_cmd_t                 cmd_reg, cmd_next;
    logic [2:0]               pend_reg, pend_next;
    logic [1:0]               k_reg, k_next;
    logic signed [PA_W-1:0]   pa_reg, pa_next;
    logic signed [PA_W-1:0]   pb_reg, pb_next;
    logic signed [COEF_W-1:0] c2_reg, c2_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [POS_W-1:0]  pos_reg [3];
    logic signed [POS_W-1:0]  pos_next [3];

    logic                     ov_reg, ov_next;
    logic                     o_kind_reg, o_kind_next;
    logic                     o_last_reg, o_last_next;
    logic                     o_fend_reg, o_fend_next;
    logic [IDX_W-1:0]         o_vidx_reg, o_vidx_next;
    logic signed [POS_W-1:0]  o_px_reg, o_px_next;
    logic signed [POS_W-1:0]  o_py_reg, o_py_next;
    logic signed [POS_W-1:0]  o_pz_reg, o_pz_next;
    logic [TRI_W-1:0]         o_tri_reg, o_tri_next;
    logic [IDX_W-1:0]         o_a_reg, o_a_next;
    logic [IDX_W-1:0]         o_b_reg, o_b_next;
    logic [IDX_W-1:0]         o_c_reg, o_c_next;

    logic [CFG_W-1:0]         row_sel;
    logic signed [COEF_W-1:0] trans_k;
    logic [XY_W:0]            xo;
    logic [XY_W:0]            yo;
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] tsum;
    logic                     out_free;

    // matrix row and translation of the current coordinate
    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                row_sel = coef.row0;
                trans_k = coef.trans[COEF_W-1:0];
            end
            2'd1:
            begin
                row_sel = coef.row1;
                trans_k = coef.trans[2*COEF_W-1:COEF_W];
            end
            default:
            begin
                row_sel = coef.row2;
                trans_k = coef.trans[3*COEF_W-1:2*COEF_W];
            end
        endcase
        xo       = {cmd_reg.x, 1'b1};
        yo       = {cmd_reg.y, 1'b1};
        rnd      = (prod_reg + PROD_W'(1024)) >>> 11;
        tsum     = rnd + (PROD_W'(trans_k) <<< 8);
        out_free = !ov_reg || m_tready;
    end

    // sequencer, datapath and result selection
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        pend_next   = pend_reg;
        k_next      = k_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        c2_next     = c2_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        pos_next    = pos_reg;
        ov_next     = ov_reg && !m_tready;
        o_kind_next = o_kind_reg;
        o_last_next = o_last_reg;
        o_fend_next = o_fend_reg;
        o_vidx_next = o_vidx_reg;
        o_px_next   = o_px_reg;
        o_py_next   = o_py_reg;
        o_pz_next   = o_pz_reg;
        o_tri_next  = o_tri_reg;
        o_a_next    = o_a_reg;
        o_b_next    = o_b_reg;
        o_c_next    = o_c_reg;
        q_pop       = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_avail)
                begin
                    q_pop     = 1'b1;
                    cmd_next  = q_data;
                    pend_next = {q_data.has_t2, q_data.has_t1, q_data.has_vtx};
                    k_next    = 2'd0;
                    if (q_data.has_vtx)
                    begin
                        state_next = B_MUL;
                    end
                    else if (q_data.has_t1 || q_data.has_t2)
                    begin
                        state_next = B_EMIT;
                    end
                end
            end
            B_MUL:
            begin
                pa_next    = PA_W'($signed(row_sel[COEF_W-1:0]))
                           * PA_W'($signed({1'b0, xo}));
                pb_next    = PA_W'($signed(row_sel[2*COEF_W-1:COEF_W]))
                           * PA_W'($signed({1'b0, yo}));
                c2_next    = $signed(row_sel[3*COEF_W-1:2*COEF_W]);
                state_next = B_SUM;
            end
            B_SUM:
            begin
                acc_next   = ACC_W'(pa_reg) + ACC_W'(pb_reg) + (ACC_W'(c2_reg) <<< 1);
                state_next = B_PROD;
            end
            B_PROD:
            begin
                prod_next  = PROD_W'(acc_reg) * PROD_W'($signed({1'b0, cmd_reg.depth}));
                state_next = B_FIN;
            end
            B_FIN:
            begin
                // saturate to the signed output range
                if (tsum > POS_MAX)
                begin
                    pos_next[k_reg] = POS_W'(POS_MAX);
                end
                else if (tsum < POS_MIN)
                begin
                    pos_next[k_reg] = POS_W'(POS_MIN);
                end
                else
                begin
                    pos_next[k_reg] = POS_W'(tsum);
                end
                if (k_reg == 2'd2)
                begin
                    state_next = B_EMIT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = B_MUL;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    o_fend_next = cmd_reg.frame_end;
                    o_vidx_next = '0;
                    o_px_next   = '0;
                    o_py_next   = '0;
                    o_pz_next   = '0;
                    o_tri_next  = '0;
                    o_a_next    = '0;
                    o_b_next    = '0;
                    o_c_next    = '0;
                    if (pend_reg[0])
                    begin
                        o_kind_next = 1'b0;
                        o_vidx_next = cmd_reg.vidx;
                        o_px_next   = pos_reg[0];
                        o_py_next   = pos_reg[1];
                        o_pz_next   = pos_reg[2];
                        pend_next   = {pend_reg[2:1], 1'b0};
                    end
                    else if (pend_reg[1])
                    begin
                        o_kind_next = 1'b1;
                        o_tri_next  = cmd_reg.tri_base;
                        o_a_next    = cmd_reg.ul;
                        o_b_next    = cmd_reg.ll;
                        o_c_next    = cmd_reg.ur;
                        pend_next   = {pend_reg[2], 2'b00};
                    end
                    else
                    begin
                        // second triangle follows the first one if both exist
                        o_kind_next = 1'b1;
                        o_tri_next  = cmd_reg.tri_base + TRI_W'(cmd_reg.has_t1);
                        o_a_next    = cmd_reg.ll;
                        o_b_next    = cmd_reg.vidx;
                        o_c_next    = cmd_reg.ur;
                        pend_next   = 3'b000;
                    end
                    o_last_next = pend_next == 3'b000;
                    if (pend_next == 3'b000)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            pend_reg  <= '0;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
        end
    end

    // datapath and output payload
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        c2_reg     <= c2_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        pos_reg    <= pos_next;
        o_kind_reg <= o_kind_next;
        o_last_reg <= o_last_next;
        o_fend_reg <= o_fend_next;
        o_vidx_reg <= o_vidx_next;
        o_px_reg   <= o_px_next;
        o_py_reg   <= o_py_next;
        o_pz_reg   <= o_pz_next;
        o_tri_reg  <= o_tri_next;
        o_a_reg    <= o_a_next;
        o_b_reg    <= o_b_next;
        o_c_reg    <= o_c_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tlast  = o_last_reg;
    assign m_tuser  = {o_fend_reg, o_kind_reg};
    assign m_tdata  = {1'b0, o_c_reg, o_b_reg, o_a_reg, o_tri_reg,
                       o_pz_reg, o_py_reg, o_px_reg, o_vidx_reg};

endmodule

[tb/sv/depth_map_to_mesh_top_test.sv]
// self-checking testbench for the depth map to mesh block
module depth_map_to_mesh_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dmm_pkg::*;

    localparam int MAXW = MAX_WIDTH_DEF;
    localparam int MAXH = MAX_HEIGHT_DEF;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd6;
    localparam logic [COEF_W-1:0] COEF_MAX = 21'h0FFFFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 21'h100000;
    localparam logic [COEF_W-1:0] COEF_ONE = 21'h040000;
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   vidx;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic [POS_W-1:0]   pz;
        logic [TRI_W-1:0]   tidx;
        logic [IDX_W-1:0]   ca;
        logic [IDX_W-1:0]   cb;
        logic [IDX_W-1:0]   cc;
        logic               last;
        logic               fend;
    } mesh_res_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DEPTH_W-1:0]    s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    depth_map_to_mesh_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // mirror of the block state
    logic [CFG_W-1:0]    m_row0, m_row1, m_row2, m_trans;
    logic [GEOCFG_W-1:0] m_width, m_height;
    logic                prev_ok [MAXW];
    logic [IDX_W-1:0]    prev_id [MAXW];
    logic                left_ok, ul_ok;
    logic [IDX_W-1:0]    left_id, ul_id;
    logic [IDX_W-1:0]    vert_count;
    logic [TRI_W-1:0]    tri_count;
    int                  col, row;

    mesh_res_t expected_mesh[$];
    int        errors;
    int        burst_left;
    int        ready_mode;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #3ms;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [CFG_W-1:0] pack3(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b,
                                               logic [COEF_W-1:0] c);
        return {c, b, a};
    endfunction

    // back projection of one coordinate with rounding and saturation
    function automatic logic [POS_W-1:0] project(logic [CFG_W-1:0] r, int x, int y,
                                                 logic [DEPTH_W-1:0] d,
                                                 logic [COEF_W-1:0] t);
        longint acc;
        longint p;
        acc = longint'($signed(r[20:0])) * (2 * x + 1)
            + longint'($signed(r[41:21])) * (2 * y + 1)
            + longint'($signed(r[62:42])) * 2;
        p = (acc * longint'(d) + 1024) >>> 11;
        p = p + longint'($signed(t)) * 256;
        if (p > 64'sd2147483647)
            p = 64'sd2147483647;
        if (p < -64'sd2147483648)
            p = -64'sd2147483648;
        return p[POS_W-1:0];
    endfunction

    function automatic void clear_rows();
        for (int i = 0; i < MAXW; i++)
        begin
            prev_ok[i] = 1'b0;
            prev_id[i] = '0;
        end
        left_ok = 1'b0;
        ul_ok = 1'b0;
    endfunction

    function automatic void mirror_reset();
        m_row0 = '0;
        m_row1 = '0;
        m_row2 = '0;
        m_trans = '0;
        m_width = WIDTH_RST;
        m_height = HEIGHT_RST;
        clear_rows();
        vert_count = '0;
        tri_count = '0;
        col = 0;
        row = 0;
    endfunction

    function automatic void mirror_write(logic [CFG_ADDR_W-1:0] a, logic [CFG_W-1:0] v);
        case (a)
            REG_ROW0:   m_row0 = v;
            REG_ROW1:   m_row1 = v;
            REG_ROW2:   m_row2 = v;
            REG_TRANS:  m_trans = v;
            REG_WIDTH:  m_width = v[GEOCFG_W-1:0];
            REG_HEIGHT: m_height = v[GEOCFG_W-1:0];
            default:    ;
        endcase
    endfunction

    // mesh results caused by one accepted pixel
    function automatic void predict_mesh(logic [DEPTH_W-1:0] d);
        mesh_res_t r;
        mesh_res_t batch[$];
        int w, h, x, y;
        logic cur_ok, ur_ok, end_row, end_frame;
        logic [IDX_W-1:0] cur_id, ur_id;
        w = (m_width < 1) ? 1 : ((m_width > MAXW) ? MAXW : m_width);
        h = (m_height < 1) ? 1 : ((m_height > MAXH) ? MAXH : m_height);
        x = (col >= MAXW) ? MAXW - 1 : col;
        y = row;
        cur_ok = 1'b0;
        cur_id = '0;
        if (d != 0)
        begin
            r = '0;
            r.kind = KIND_VERTEX;
            r.vidx = vert_count;
            r.px = project(m_row0, x, y, d, m_trans[20:0]);
            r.py = project(m_row1, x, y, d, m_trans[41:21]);
            r.pz = project(m_row2, x, y, d, m_trans[62:42]);
            batch = {batch, r};
            cur_ok = 1'b1;
            cur_id = vert_count;
            vert_count++;
        end
        ur_ok = prev_ok[x];
        ur_id = prev_id[x];
        // upper triangle then lower triangle of the quad
        if (ul_ok && left_ok && ur_ok)
        begin
            r = '0;
            r.kind = KIND_TRIANGLE;
            r.tidx = tri_count;
            r.ca = ul_id;
            r.cb = left_id;
            r.cc = ur_id;
            batch = {batch, r};
            tri_count++;
        end
        if (left_ok && cur_ok && ur_ok)
        begin
            r = '0;
            r.kind = KIND_TRIANGLE;
            r.tidx = tri_count;
            r.ca = left_id;
            r.cb = cur_id;
            r.cc = ur_id;
            batch = {batch, r};
            tri_count++;
        end
        prev_ok[x] = cur_ok;
        prev_id[x] = cur_id;
        ul_ok = ur_ok;
        ul_id = ur_id;
        left_ok = cur_ok;
        left_id = cur_id;
        end_row = (x + 1) >= w;
        end_frame = end_row && ((y + 1) >= h);
        if (end_row)
        begin
            col = 0;
            left_ok = 1'b0;
            ul_ok = 1'b0;
            row = (y + 1 < MAXH) ? y + 1 : MAXH - 1;
        end
        else
            col = x + 1;
        if (end_frame)
        begin
            clear_rows();
            vert_count = '0;
            tri_count = '0;
            col = 0;
            row = 0;
        end
        foreach (batch[k])
        begin
            batch[k].last = (k == batch.size() - 1);
            batch[k].fend = end_frame;
            expected_mesh = {expected_mesh, batch[k]};
        end
    endfunction

    // send one pixel, bursts separated by random gaps
    task automatic send_pixel(logic [DEPTH_W-1:0] d);
        @(negedge clk);
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 14);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata = d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_mesh(d);
    endtask

    // let every expected result arrive, then let the block settle
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_mesh.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = a;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        mirror_write(a, v);
    endtask

    function automatic logic [DEPTH_W-1:0] rand_depth();
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3:       return 16'hFFFF;
            4:       return DEPTH_W'($urandom_range(1, 15));
            default: return DEPTH_W'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_reg();
        return CFG_W'({$urandom, $urandom});
    endfunction

    // extreme coefficients, depths and saturation on a 3x2 frame
    task automatic test_directed();
        // default geometry first, then a mid-frame change to a narrow row
        send_pixel(16'd100);
        send_pixel(16'd0);
        wait_drained();
        write_reg(REG_WIDTH, 63'd3);
        write_reg(REG_HEIGHT, 63'd2);
        write_reg(REG_ROW0, pack3(COEF_MAX, COEF_MIN, COEF_MAX));
        write_reg(REG_ROW1, pack3(COEF_MIN, COEF_MAX, COEF_MIN));
        write_reg(REG_ROW2, pack3(COEF_ONE, '0, COEF_ONE));
        write_reg(REG_TRANS, pack3(COEF_MAX, COEF_MIN, '0));
        // frame ends where it was, then a full frame
        send_pixel(16'hFFFF);
        send_pixel(16'd1);
        send_pixel(16'hFFFF);
        send_pixel(16'd1);
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);
        send_pixel(16'hFFFF);
        // missing middle pixel of the top row and missing lower-left pixel
        send_pixel(16'h8000);
        send_pixel(16'h0001);
        send_pixel(16'h7FFF);
        send_pixel(16'd0);
        send_pixel(16'h1234);
        send_pixel(16'd0);
        wait_drained();
        // unknown register index is ignored
        write_reg(REG_UNUSED, {CFG_W{1'b1}});
        send_pixel(16'd5);
        send_pixel(16'd7);
        send_pixel(16'd9);
        send_pixel(16'd11);
        wait_drained();
    endtask

    // geometry below one, above the maximum and at the bounds
    task automatic test_geometry_clamp();
        write_reg(REG_WIDTH, 63'd0);
        write_reg(REG_HEIGHT, 63'd0);
        send_pixel(16'd3);
        send_pixel(16'd0);
        wait_drained();
        write_reg(REG_WIDTH, 63'hFFF);
        write_reg(REG_HEIGHT, 63'hFFF);
        send_pixel(16'd200);
        send_pixel(16'd300);
        wait_drained();
        write_reg(REG_WIDTH, 63'd2048);
        write_reg(REG_HEIGHT, 63'd1);
        send_pixel(16'd400);
        wait_drained();
        write_reg(REG_WIDTH, 63'd1);
        write_reg(REG_HEIGHT, 63'd2048);
        send_pixel(16'd1);
        wait_drained();
    endtask

    // random transforms on small frames with random depths
    task automatic test_random();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_ROW0, rand_reg());
            write_reg(REG_ROW1, rand_reg());
            write_reg(REG_ROW2, rand_reg());
            write_reg(REG_TRANS, rand_reg());
            write_reg(REG_WIDTH, CFG_W'($urandom_range(1, 7)));
            write_reg(REG_HEIGHT, CFG_W'($urandom_range(1, 5)));
            if (ph == 3)
                write_reg(REG_UNUSED, rand_reg());
            // pixels go on from the current position, not from a frame boundary
            col = col;
            for (int i = 0; i < 24; i++)
                send_pixel(rand_depth());
            wait_drained();
        end
    endtask

    // receiver stalls on its own pattern
    initial
    begin
        m_tready = 1'b0;
        ready_mode = 0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                ready_mode = $urandom_range(0, 3);
            case (ready_mode)
                0:       m_tready = 1'b1;
                1:       m_tready = ($urandom_range(0, 1) == 1);
                2:       m_tready = ($urandom_range(0, 7) != 0);
                default: m_tready = ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // result checker
    initial
    begin
        mesh_res_t got;
        mesh_res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.kind = m_tuser[0];
                got.fend = m_tuser[1];
                got.last = m_tlast;
                got.vidx = m_tdata[21:0];
                got.px = m_tdata[53:22];
                got.py = m_tdata[85:54];
                got.pz = m_tdata[117:86];
                got.tidx = m_tdata[140:118];
                got.ca = m_tdata[162:141];
                got.cb = m_tdata[184:163];
                got.cc = m_tdata[206:185];
                if (expected_mesh.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %p", got);
                end
                else
                begin
                    want = expected_mesh.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch\n  expected %p\n  actual   %p", want, got);
                    end
                end
            end
        end
    end

    // stimulus
    initial
    begin
        errors = 0;
        burst_left = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mirror_reset();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_geometry_clamp();
        test_random();
        wait_drained();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/dmm_pkg.sv
rtl/core/dmm_queue.sv
rtl/core/dmm_front.sv
rtl/core/dmm_back.sv
rtl/core/depth_map_to_mesh_top.sv
tb/sv/depth_map_to_mesh_top_test.sv
